// ===== rtl/upc_pkg.sv =====
// ----------------------------------------------------------------------------
// upc_pkg: shared types and constants for the Unix time to calendar block
// Step codes, controller state encoding, command struct and the reciprocal
// constants used for the divisions by constants.
// ----------------------------------------------------------------------------
package upc_pkg;

  localparam int unsigned SecW  = 36;
  localparam int unsigned ZoneW = 17;
  localparam int unsigned AdjW  = 38;
  localparam int unsigned SeqW  = 20;

  localparam logic [SeqW-1:0] SeqLast = 20'd999999;

  // Julian day of the Unix epoch plus the method's 68569 bias
  localparam logic [21:0] JdBias = 22'd2509157;

  // floor(x / d) == (x * ceil(2^k / d)) >> k for x < 2^N when k >= N + ceil(log2 d)
  localparam int unsigned KDay = 40;  // x < 2^30, d = 675
  localparam int unsigned KN   = 42;  // x < 2^24, d = 146097
  localparam int unsigned KHr  = 29;  // x < 2^17, d = 3600
  localparam int unsigned KMin = 18;  // x < 2^12, d = 60
  localparam int unsigned KI   = 49;  // x < 2^28, d = 1461001
  localparam int unsigned KJ   = 31;  // x < 2^19, d = 2447
  localparam int unsigned K80  = 24;  // x < 2^17, d = 80
  localparam int unsigned K11  = 9;   // x < 2^5,  d = 11

  localparam longint unsigned MDayL = ((64'd1 << KDay) + 64'd674) / 64'd675;
  localparam longint unsigned MNL   = ((64'd1 << KN) + 64'd146096) / 64'd146097;
  localparam longint unsigned MHrL  = ((64'd1 << KHr) + 64'd3599) / 64'd3600;
  localparam longint unsigned MMinL = ((64'd1 << KMin) + 64'd59) / 64'd60;
  localparam longint unsigned MIL   = ((64'd1 << KI) + 64'd1461000) / 64'd1461001;
  localparam longint unsigned MJL   = ((64'd1 << KJ) + 64'd2446) / 64'd2447;
  localparam longint unsigned M80L  = ((64'd1 << K80) + 64'd79) / 64'd80;
  localparam longint unsigned M11L  = ((64'd1 << K11) + 64'd10) / 64'd11;

  localparam logic [30:0] MDay = MDayL[30:0];
  localparam logic [24:0] MN   = MNL[24:0];
  localparam logic [17:0] MHr  = MHrL[17:0];
  localparam logic [12:0] MMin = MMinL[12:0];
  localparam logic [28:0] MI   = MIL[28:0];
  localparam logic [19:0] MJ   = MJL[19:0];
  localparam logic [17:0] M80  = M80L[17:0];
  localparam logic [5:0]  M11  = M11L[5:0];

  typedef enum logic [4:0] {
    STEP_DAY  = 5'd0,
    STEP_TOD  = 5'd1,
    STEP_N    = 5'd2,
    STEP_L2   = 5'd3,
    STEP_X    = 5'd4,
    STEP_I    = 5'd5,
    STEP_L3   = 5'd6,
    STEP_J    = 5'd7,
    STEP_K    = 5'd8,
    STEP_D    = 5'd9,
    STEP_Y    = 5'd10,
    STEP_P_MM = 5'd11,
    STEP_P_DD = 5'd12,
    STEP_P_HH = 5'd13,
    STEP_P_MN = 5'd14,
    STEP_P_SS = 5'd15,
    STEP_P_SQ = 5'd16
  } step_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic  load;
    logic  calc;
    step_e step;
    logic  publish;
  } dp_cmd_t;

endpackage

// ===== rtl/upc_in_if.sv =====
// ----------------------------------------------------------------------------
// upc_in_if: input channel
// One beat carries one Unix seconds count.
// ----------------------------------------------------------------------------
interface upc_in_if;
  logic        valid;
  logic        ready;
  logic [35:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink   (input valid, input unix_seconds, output ready);
endinterface

// ===== rtl/upc_out_if.sv =====
// ----------------------------------------------------------------------------
// upc_out_if: result channel
// One beat carries the packed calendar word and its fields.
// ----------------------------------------------------------------------------
interface upc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] packed_clock;
  logic [9:0]  year_since_2000;
  logic [3:0]  month_number;
  logic [4:0]  day_of_month;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;
  logic [5:0]  second_of_minute;
  logic [19:0] sequence_number;
  logic        out_of_range;

  modport source (output valid, output packed_clock, output year_since_2000,
                  output month_number, output day_of_month, output hour_of_day,
                  output minute_of_hour, output second_of_minute,
                  output sequence_number, output out_of_range, input ready);
  modport sink   (input valid, input packed_clock, input year_since_2000,
                  input month_number, input day_of_month, input hour_of_day,
                  input minute_of_hour, input second_of_minute,
                  input sequence_number, input out_of_range, output ready);
endinterface

// ===== rtl/upc_ctrl.sv =====
// ----------------------------------------------------------------------------
// upc_ctrl: sequencer
// Steps the datapath through the conversion and owns the result valid flag.
// ----------------------------------------------------------------------------
module upc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output upc_pkg::dp_cmd_t cmd_o
);
  import upc_pkg::*;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   publish;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign publish     = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CALC;
          step_d  = STEP_DAY;
        end
      end
      ST_CALC: begin
        if (step_q == STEP_P_SQ) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_e'(step_q + 5'd1);
        end
      end
      ST_DONE: begin
        if (publish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign cmd_o.load    = in_fire;
  assign cmd_o.calc    = (state_q == ST_CALC);
  assign cmd_o.step    = step_q;
  assign cmd_o.publish = publish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_DAY;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_CALC) && (step_q == STEP_DAY))
    else $error("accepted beat did not start the step sequence");
  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    publish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> (step_q <= STEP_P_SQ))
    else $error("step code beyond the last step");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CALC) && (step_q == STEP_P_SQ)) |=> (state_q == ST_DONE))
    else $error("sequence did not finish after the last step");
`endif
endmodule

// ===== rtl/upc_dp.sv =====
// ----------------------------------------------------------------------------
// upc_dp: datapath
// Zone register, sequence counter, the Julian-day and time-of-day steps,
// the decimal packing and the result register.
// ----------------------------------------------------------------------------
module upc_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [16:0]      cfg_wdata_i,
  input  upc_pkg::dp_cmd_t cmd_i,
  input  logic [35:0]      unix_seconds_i,
  output logic [63:0]      packed_clock_o,
  output logic [9:0]       year_since_2000_o,
  output logic [3:0]       month_number_o,
  output logic [4:0]       day_of_month_o,
  output logic [4:0]       hour_of_day_o,
  output logic [5:0]       minute_of_hour_o,
  output logic [5:0]       second_of_minute_o,
  output logic [19:0]      sequence_number_o,
  output logic             out_of_range_o
);
  import upc_pkg::*;

  logic [ZoneW-1:0] zone_q;
  logic [SeqW-1:0]  seq_cnt_q, seq_q;
  logic [AdjW-1:0]  adj_q, adj_d;

  logic [20:0] days_q;
  logic [16:0] tod_q;
  logic [21:0] l_q;
  logic [6:0]  n_q;
  logic [4:0]  hh_q;
  logic [11:0] trem_q;
  logic [27:0] x_q;
  logic [5:0]  mn_q;
  logic [6:0]  i_q;
  logic [5:0]  ss_q;
  logic [4:0]  j_q;
  logic [16:0] kx_q;
  logic [4:0]  dd_q;
  logic [1:0]  l4_q;
  logic [3:0]  mm_q;
  logic [13:0] yr_q;
  logic        bad_q;
  logic [63:0] acc_q;

  // step products
  logic [60:0] p_day;
  logic [30:0] p_tod;
  logic [29:0] rem_day;
  logic [48:0] p_n;
  logic [34:0] p_hr;
  logic [24:0] p_l2;
  logic [16:0] p_trem;
  logic [28:0] p_x;
  logic [24:0] p_min;
  logic [56:0] p_i;
  logic [11:0] p_ss;
  logic [17:0] p_l3;
  logic [18:0] y80;
  logic [38:0] p_j;
  logic [34:0] p_d;
  logic [21:0] dd_full;
  logic [10:0] p_l4;
  logic [4:0]  mm_full;
  logic [13:0] yr_d;
  logic [9:0]  yy;
  logic [63:0] acc_x100;
  logic [63:0] acc_fin;

  assign adj_d = {2'b00, unix_seconds_i} + {{(AdjW-ZoneW){zone_q[ZoneW-1]}}, zone_q};

  assign p_day   = adj_q[36:7] * MDay;
  assign p_tod   = days_q * 10'd675;
  assign rem_day = adj_q[36:7] - p_tod[29:0];
  assign p_n     = {l_q, 2'b00} * MN;
  assign p_hr    = tod_q * MHr;
  assign p_l2    = n_q * 18'd146097 + 25'd3;
  assign p_trem  = tod_q - hh_q * 17'd3600;
  assign p_x     = ({1'b0, l_q[15:0]} + 17'd1) * 12'd4000;
  assign p_min   = trem_q * MMin;
  assign p_i     = x_q * MI;
  assign p_ss    = trem_q - mn_q * 12'd60;
  assign p_l3    = i_q * 11'd1461;
  assign y80     = l_q[11:0] * 7'd80;
  assign p_j     = y80 * MJ;
  assign p_d     = kx_q * M80;
  assign dd_full = l_q - {11'd0, p_d[34:24]};
  assign p_l4    = j_q * M11;
  assign mm_full = j_q + 5'd2 - 5'd12 * {3'd0, l4_q};
  assign yr_d    = n_q * 7'd100 - 14'd4900 + {7'd0, i_q} + {12'd0, l4_q};
  assign yy      = 10'(yr_q - 14'd2000);
  assign acc_x100 = acc_q * 7'd100;
  assign acc_fin  = acc_q * 20'd1000000 + {44'd0, seq_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q    <= '0;
      seq_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        zone_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        seq_cnt_q <= (seq_cnt_q == SeqLast) ? '0 : seq_cnt_q + 20'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      adj_q <= adj_d;
      seq_q <= seq_cnt_q;
    end
    if (cmd_i.calc) begin
      case (cmd_i.step)
        STEP_DAY: days_q <= p_day[60:40];
        STEP_TOD: begin
          tod_q <= {rem_day[9:0], adj_q[6:0]};
          l_q   <= {1'b0, days_q} + JdBias;
        end
        STEP_N: begin
          n_q  <= p_n[48:42];
          hh_q <= p_hr[33:29];
        end
        STEP_L2: begin
          l_q    <= l_q - p_l2[23:2];
          trem_q <= p_trem[11:0];
        end
        STEP_X: begin
          x_q  <= p_x[27:0];
          mn_q <= p_min[23:18];
        end
        STEP_I: begin
          i_q  <= p_i[55:49];
          ss_q <= p_ss[5:0];
        end
        STEP_L3: l_q <= l_q - {6'd0, p_l3[17:2]} + 22'd31;
        STEP_J:  j_q <= p_j[35:31];
        STEP_K:  kx_q <= j_q * 12'd2447;
        STEP_D: begin
          dd_q <= dd_full[4:0];
          l4_q <= p_l4[10:9];
        end
        STEP_Y: begin
          mm_q  <= mm_full[3:0];
          yr_q  <= yr_d;
          bad_q <= adj_q[AdjW-1] || (yr_d < 14'd2000) || (yr_d > 14'd2999);
        end
        STEP_P_MM: acc_q <= {54'd0, yy} * 7'd100 + {60'd0, mm_q};
        STEP_P_DD: acc_q <= acc_x100 + {59'd0, dd_q};
        STEP_P_HH: acc_q <= acc_x100 + {59'd0, hh_q};
        STEP_P_MN: acc_q <= acc_x100 + {58'd0, mn_q};
        STEP_P_SS: acc_q <= acc_x100 + {58'd0, ss_q};
        STEP_P_SQ: acc_q <= acc_fin;
        default: begin
        end
      endcase
    end
    if (cmd_i.publish) begin
      packed_clock_o     <= bad_q ? '0 : acc_q;
      year_since_2000_o  <= bad_q ? '0 : yy;
      month_number_o     <= bad_q ? '0 : mm_q;
      day_of_month_o     <= bad_q ? '0 : dd_q;
      hour_of_day_o      <= bad_q ? '0 : hh_q;
      minute_of_hour_o   <= bad_q ? '0 : mn_q;
      second_of_minute_o <= bad_q ? '0 : ss_q;
      sequence_number_o  <= seq_q;
      out_of_range_o     <= bad_q;
    end
  end
endmodule

// ===== rtl/unix_time_to_packed_calendar.sv =====
// ----------------------------------------------------------------------------
// unix_time_to_packed_calendar: Unix seconds to Gregorian date and packed word
// Adds the zone offset, converts with the Julian-day method and packs
// YYYMMDDhhmmss plus a six-digit running sequence number.
// ----------------------------------------------------------------------------
// Usage:
//   in_s  : one beat per Unix seconds count (valid/ready).
//   out_m : one beat per input beat, in order: packed_clock plus the
//           separate fields and the out_of_range flag.
//   cfg_we_i/cfg_wdata_i : writes the signed 17-bit zone offset; write only
//           while no beat is in flight.
// Sequence: after the accepting edge the sequencer runs its 17 steps, then
//   publishes into the result register once that register is free.
// Order: the sequencer walks the Julian-day chain step by step, mostly with
//   reciprocal multiplies, each step using results of earlier steps.
// in_s.ready is high only while the sequencer is idle; the result register
//   is separate, so a new beat is taken while the previous result waits.
// Stall: a finished result waits in the sequencer until out_m frees the
//   result register; nothing is dropped.
// Reset: zone offset 0, sequence counter 0, no result pending.
// Years outside 2000..2999 (or a negative adjusted time) give all-zero date
//   and time fields and packed word, out_of_range set, sequence still counted.
// ----------------------------------------------------------------------------
module unix_time_to_packed_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  upc_in_if.sink      in_s,
  upc_out_if.source   out_m
);
  import upc_pkg::*;

  dp_cmd_t cmd;

  upc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_s.ready),
    .out_valid_o (out_m.valid),
    .out_ready_i (out_m.ready),
    .cmd_o       (cmd)
  );

  upc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .cmd_i              (cmd),
    .unix_seconds_i     (in_s.unix_seconds),
    .packed_clock_o     (out_m.packed_clock),
    .year_since_2000_o  (out_m.year_since_2000),
    .month_number_o     (out_m.month_number),
    .day_of_month_o     (out_m.day_of_month),
    .hour_of_day_o      (out_m.hour_of_day),
    .minute_of_hour_o   (out_m.minute_of_hour),
    .second_of_minute_o (out_m.second_of_minute),
    .sequence_number_o  (out_m.sequence_number),
    .out_of_range_o     (out_m.out_of_range)
  );
endmodule
